// File: hw/rtl/ckey_pkg.sv
`default_nettype none

package ckey_pkg;

   localparam int COMP_W = 16;
   // sum of three squared 16-bit differences fits in 34 bits
   localparam int RAD_W  = 34;
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 4;
   localparam int CALC_W = 20;

   // BT.601 luma weights, scaled so that they sum to 65536
   localparam logic [15:0] LUMA_WR   = 16'd19595;
   localparam logic [15:0] LUMA_WG   = 16'd38470;
   localparam logic [15:0] LUMA_WB   = 16'd7471;
   localparam logic [31:0] LUMA_BIAS = 32'd32768;

   typedef enum logic [2:0] {
      CSR_PIXEL_FORMAT = 3'd0,
      CSR_USE_LUMA     = 3'd1,
      CSR_KEY_A        = 3'd2,
      CSR_KEY_B        = 3'd3,
      CSR_KEY_C        = 3'd4,
      CSR_KEY_LUMA     = 3'd5,
      CSR_THRESHOLD    = 3'd6,
      CSR_RAMP_RUN     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic              pixel_format;
      logic              use_luma;
      logic [COMP_W-1:0] key_a;
      logic [COMP_W-1:0] key_b;
      logic [COMP_W-1:0] key_c;
      logic [COMP_W-1:0] key_luma;
      logic [COMP_W-1:0] threshold;
      logic [COMP_W-1:0] ramp_run;
   } cfg_type;

   // one pixel as it moves down the square root chain
   typedef struct packed {
      logic              valid;
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [COMP_W-1:0] luma;
      logic [COMP_W-1:0] alpha_in;
   } slot_type;

endpackage

`default_nettype wire

// File: hw/rtl/ckey_front.sv
`default_nettype none

module ckey_front (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 en,
   input  wire                                 in_valid,
   input  wire ckey_pkg::cfg_type              cfg,
   input  wire  [ckey_pkg::COMP_W-1:0]         comp_a,
   input  wire  [ckey_pkg::COMP_W-1:0]         comp_b,
   input  wire  [ckey_pkg::COMP_W-1:0]         comp_c,
   input  wire  [ckey_pkg::COMP_W-1:0]         alpha_in,
   output ckey_pkg::slot_type                  slot_out
);

   localparam int W = ckey_pkg::COMP_W;

   // stage 1: absolute differences
   logic         v1_ff, v1_in;
   logic [W-1:0] da_ff, db_ff, dc_ff, ca_ff, cb_ff, cc_ff, a1_ff;
   // stage 2: squares and weighted components
   logic         v2_ff, v2_in;
   logic [31:0]  sa_ff, sb_ff, sc_ff, pr_ff, pg_ff, pb_ff;
   logic [W-1:0] a2_ff, y2_ff;
   // stage 3: sums
   logic                        v3_ff, v3_in;
   logic [ckey_pkg::RAD_W-1:0]  rad_ff;
   logic [W-1:0]                luma_ff, a3_ff;
   logic [31:0]                 luma_sum;

   assign v1_in = en ? in_valid : v1_ff;
   assign v2_in = en ? v1_ff : v2_ff;
   assign v3_in = en ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   assign luma_sum = pr_ff + pg_ff + pb_ff + ckey_pkg::LUMA_BIAS;

   always_ff @(posedge clock) begin
      if (en) begin
         da_ff   <= (comp_a > cfg.key_a) ? comp_a - cfg.key_a : cfg.key_a - comp_a;
         db_ff   <= (comp_b > cfg.key_b) ? comp_b - cfg.key_b : cfg.key_b - comp_b;
         dc_ff   <= (comp_c > cfg.key_c) ? comp_c - cfg.key_c : cfg.key_c - comp_c;
         ca_ff   <= comp_a;
         cb_ff   <= comp_b;
         cc_ff   <= comp_c;
         a1_ff   <= alpha_in;

         sa_ff   <= da_ff * da_ff;
         sb_ff   <= db_ff * db_ff;
         sc_ff   <= dc_ff * dc_ff;
         pr_ff   <= ca_ff * ckey_pkg::LUMA_WR;
         pg_ff   <= cb_ff * ckey_pkg::LUMA_WG;
         pb_ff   <= cc_ff * ckey_pkg::LUMA_WB;
         a2_ff   <= a1_ff;
         y2_ff   <= ca_ff;

         rad_ff  <= ckey_pkg::RAD_W'(sa_ff) + ckey_pkg::RAD_W'(sb_ff)
                    + ckey_pkg::RAD_W'(sc_ff);
         // in AYUV the Y component is the luma; it replaces the weighted sum
         luma_ff <= cfg.pixel_format ? y2_ff : luma_sum[31:16];
         a3_ff   <= a2_ff;
      end
   end

   always_comb begin
      slot_out          = '0;
      slot_out.valid    = v3_ff;
      slot_out.rad      = rad_ff;
      slot_out.luma     = luma_ff;
      slot_out.alpha_in = a3_ff;
   end

endmodule

`default_nettype wire

// File: hw/rtl/ckey_sqrt_cell.sv
`default_nettype none

module ckey_sqrt_cell (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      en,
   input  wire ckey_pkg::slot_type  slot_in,
   output ckey_pkg::slot_type       slot_out
);

   localparam int RW = ckey_pkg::REM_W;
   localparam int QW = ckey_pkg::ROOT_W;
   localparam int DW = ckey_pkg::RAD_W;

   ckey_pkg::slot_type slot_ff, slot_in_next;
   logic [RW-1:0]      rem_sh, trial;
   logic               take;
   logic               valid_ff_in;

   // bring down the next digit pair and try root*4+1
   assign rem_sh = {slot_in.rem[RW-3:0], slot_in.rad[DW-1 -: 2]};
   assign trial  = RW'({slot_in.root, 2'b01});
   assign take   = (rem_sh >= trial);

   always_comb begin
      slot_in_next       = slot_in;
      slot_in_next.rad   = {slot_in.rad[DW-3:0], 2'b00};
      slot_in_next.rem   = take ? rem_sh - trial : rem_sh;
      slot_in_next.root  = {slot_in.root[QW-2:0], take};
   end

   assign valid_ff_in = en ? slot_in.valid : slot_ff.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff.valid <= valid_ff_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         slot_ff.rad      <= slot_in_next.rad;
         slot_ff.rem      <= slot_in_next.rem;
         slot_ff.root     <= slot_in_next.root;
         slot_ff.luma     <= slot_in_next.luma;
         slot_ff.alpha_in <= slot_in_next.alpha_in;
      end
   end

   assign slot_out = slot_ff;

endmodule

`default_nettype wire

// File: hw/rtl/ckey_alpha.sv
`default_nettype none

module ckey_alpha #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              en,
   input  wire ckey_pkg::cfg_type           cfg,
   input  wire ckey_pkg::slot_type          slot_in,
   output logic                             out_valid,
   output logic [ckey_pkg::COMP_W-1:0]      out_alpha
);

   localparam int W  = ckey_pkg::COMP_W;
   localparam int CW = ckey_pkg::CALC_W;
   localparam int QW = ckey_pkg::ROOT_W;
   localparam logic [W-1:0] OPAQUE = W'((64'd1 << SAMPLE_BITS) - 64'd1);

   logic                 valid_ff, valid_in;
   logic [W-1:0]         alpha_ff, alpha_in;
   logic [QW:0]          round_dist;
   logic signed [CW-1:0] thr_s, run_s, cur_s, key_s, dist_s;
   logic signed [CW-1:0] diff_c, lo, hi, dlo, dhi;
   logic [W-1:0]         keyed;

   // round to nearest: remainder above the root means the upper integer is closer
   assign round_dist = {1'b0, slot_in.root}
                       + (QW+1)'(slot_in.rem > ckey_pkg::REM_W'(slot_in.root));

   assign thr_s  = CW'($signed({1'b0, cfg.threshold}));
   assign run_s  = CW'($signed({1'b0, cfg.ramp_run}));
   assign cur_s  = CW'($signed({1'b0, slot_in.luma}));
   assign key_s  = CW'($signed({1'b0, cfg.key_luma}));
   assign dist_s = CW'($signed({1'b0, round_dist}));

   assign diff_c = dist_s - thr_s;
   assign lo     = key_s - thr_s;
   assign hi     = key_s + thr_s;
   assign dlo    = lo - cur_s;
   assign dhi    = cur_s - hi;

   always_comb begin
      keyed = OPAQUE;
      if (cfg.use_luma) begin
         if (cur_s < lo) begin
            if (dlo < run_s) begin
               keyed = dlo[W-1:0];
            end
         end else if (cur_s >= hi) begin
            if (dhi < run_s) begin
               keyed = dhi[W-1:0];
            end
         end else begin
            keyed = '0;
         end
      end else begin
         if (diff_c < 0) begin
            keyed = '0;
         end else if (diff_c < run_s) begin
            keyed = diff_c[W-1:0];
         end
      end
   end

   always_comb begin
      if (cfg.threshold == '0) begin
         alpha_in = slot_in.alpha_in;
      end else if (slot_in.alpha_in < keyed) begin
         alpha_in = slot_in.alpha_in;
      end else begin
         alpha_in = keyed;
      end
   end

   assign valid_in = en ? slot_in.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         alpha_ff <= alpha_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_alpha = alpha_ff;

endmodule

`default_nettype wire

// File: hw/rtl/chroma_key_alpha.sv
`default_nettype none

// Chroma key alpha generator. Takes one pixel per clock on the req stream and
// returns one alpha per pixel on the rsp stream, in order. A pixel passes
// three front stages (differences, squares and luma weights, sums), a chain
// of 17 square root cells that settle one root bit each, and one stage that
// rounds the distance, applies the threshold and ramp, and takes the minimum
// with the pixel's own alpha. The whole pipeline advances together and holds
// while a finished alpha waits on rsp_tready. Registers must be written on the
// csr port only while no pixel is in flight; the block does not enforce this.
module chroma_key_alpha #(
   parameter int SAMPLE_BITS = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // comp_a[15:0], comp_b[31:16], comp_c[47:32], alpha_in[63:48]
   input  wire  [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // alpha_out[15:0]
   output logic [15:0] rsp_tdata,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [2:0]  csr_index,
   input  wire  [15:0] csr_data
);

   localparam int QW = ckey_pkg::ROOT_W;

   ckey_pkg::cfg_type  cfg_ff;
   ckey_pkg::slot_type slot [0:QW];
   logic               en;

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_format <= 1'b0;
         cfg_ff.use_luma     <= 1'b0;
         cfg_ff.key_a        <= '0;
         cfg_ff.key_b        <= '0;
         cfg_ff.key_c        <= '0;
         cfg_ff.key_luma     <= '0;
         cfg_ff.threshold    <= 16'd39321;
         cfg_ff.ramp_run     <= 16'd65535;
      end else if (csr_valid && csr_ready) begin
         unique case (ckey_pkg::csr_index_type'(csr_index))
            ckey_pkg::CSR_PIXEL_FORMAT: cfg_ff.pixel_format <= csr_data[0];
            ckey_pkg::CSR_USE_LUMA:     cfg_ff.use_luma     <= csr_data[0];
            ckey_pkg::CSR_KEY_A:        cfg_ff.key_a        <= csr_data;
            ckey_pkg::CSR_KEY_B:        cfg_ff.key_b        <= csr_data;
            ckey_pkg::CSR_KEY_C:        cfg_ff.key_c        <= csr_data;
            ckey_pkg::CSR_KEY_LUMA:     cfg_ff.key_luma     <= csr_data;
            ckey_pkg::CSR_THRESHOLD:    cfg_ff.threshold    <= csr_data;
            ckey_pkg::CSR_RAMP_RUN:     cfg_ff.ramp_run     <= csr_data;
            default: ;
         endcase
      end
   end

   ckey_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .cfg      (cfg_ff),
      .comp_a   (req_tdata[15:0]),
      .comp_b   (req_tdata[31:16]),
      .comp_c   (req_tdata[47:32]),
      .alpha_in (req_tdata[63:48]),
      .slot_out (slot[0])
   );

   for (genvar i = 0; i < QW; i++) begin : g_sqrt
      ckey_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .slot_in  (slot[i]),
         .slot_out (slot[i+1])
      );
   end

   ckey_alpha #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_alpha (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .cfg       (cfg_ff),
      .slot_in   (slot[QW]),
      .out_valid (rsp_tvalid),
      .out_alpha (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while result stalled");

   a_root_to_output: assert property (@(posedge clock) disable iff (reset)
      slot[QW].valid && en |=> rsp_tvalid)
      else $error("finished root lost before output");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      slot[QW].valid |-> slot[QW].rem <= ckey_pkg::REM_W'({slot[QW].root, 1'b0}))
      else $error("square root remainder out of range");

   a_front_to_chain: assert property (@(posedge clock) disable iff (reset)
      slot[0].valid && en |=> slot[1].valid)
      else $error("pixel dropped entering root chain");
`endif

endmodule

`default_nettype wire
